/* rtl/nbst_pkg.sv */
// Package for the nearest bone segment tracker: field widths, sequencer states
// and the control bundle of the shared multiply-accumulate unit.
// Used by nbst_mac, nbst_div and nearest_bone_segment_tracker; depends on nothing.
`default_nettype none

package nbst_pkg;

    // Input and output field widths.
    localparam int COORD_W   = 24;
    localparam int JOINT_W   = 8;
    localparam int RUN_W     = 2;
    localparam int ALPHA_W   = 17;
    localparam int THR_W     = 40;

    // Bit positions inside the run-position code.
    localparam int RUN_FORCE = 0;
    localparam int RUN_LAST  = 1;

    // Stream payload widths.
    localparam int S_DATA_W  = 9 * COORD_W + 2 * JOINT_W;
    localparam int M_DATA_W  = 40;

    // Datapath widths. A coordinate difference needs one bit more than a
    // coordinate; the projected residual needs one more again.
    localparam int DIFF_W    = COORD_W + 1;
    localparam int OP_W      = COORD_W + 2;
    localparam int PROD_W    = 2 * OP_W;
    localparam int ACC_W     = PROD_W + 1;
    localparam int LEN_W     = 2 * COORD_W + 2;
    localparam int DIST_W    = 52;
    localparam int FRAC_BITS = 16;

    localparam logic [ALPHA_W-1:0] ALPHA_ONE = ALPHA_W'(65536);
    localparam logic [THR_W-1:0]   THR_RESET = THR_W'(1);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LEN,
        ST_DPA,
        ST_DOT,
        ST_DECIDE,
        ST_DIV,
        ST_SCALE,
        ST_RSQ,
        ST_DPB,
        ST_UPDATE
    } t_state;

    typedef struct packed {
        logic mul_en;
        logic acc_clr;
        logic acc_en;
    } t_mac_ctl;

endpackage

`default_nettype wire

/* rtl/nbst_mac.sv */
// Shared multiply-accumulate unit of the nearest bone segment tracker.
// One signed multiply per cycle into a product register, then accumulation.
// Depends on nbst_pkg.
`default_nettype none

module nbst_mac (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    input  wire nbst_pkg::t_mac_ctl                     i_ctl,
    input  wire logic signed [nbst_pkg::OP_W-1:0]       i_op_a,
    input  wire logic signed [nbst_pkg::OP_W-1:0]       i_op_b,
    output logic signed [nbst_pkg::PROD_W-1:0]          o_prod,
    output logic signed [nbst_pkg::ACC_W-1:0]           o_sum
);

    logic signed [nbst_pkg::PROD_W-1:0] r_prod;
    logic signed [nbst_pkg::ACC_W-1:0]  r_acc;

    always_ff @(posedge i_clk) begin
        if (i_ctl.mul_en) begin
            r_prod <= i_op_a * i_op_b;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
        end else if (i_ctl.acc_clr) begin
            r_acc <= '0;
        end else if (i_ctl.acc_en) begin
            r_acc <= o_sum;
        end
    end

    // The running sum plus the product in flight; the sequencer samples this
    // on the cycle after the last multiply of a three-term sum.
    assign o_sum  = r_acc + nbst_pkg::ACC_W'(r_prod);
    assign o_prod = r_prod;

endmodule

`default_nettype wire

/* rtl/nbst_div.sv */
// Restoring radix-2 fraction divider of the nearest bone segment tracker.
// Computes floor(65536 * num / den) for num < den, one quotient bit per cycle.
// Depends on nbst_pkg.
`default_nettype none

module nbst_div (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_start,
    input  wire logic [nbst_pkg::LEN_W-1:0]           i_num,
    input  wire logic [nbst_pkg::LEN_W-1:0]           i_den,
    output logic                                      o_done,
    output logic [nbst_pkg::FRAC_BITS-1:0]            o_quot
);

    localparam int CNT_W = $clog2(nbst_pkg::FRAC_BITS);

    logic [nbst_pkg::LEN_W-1:0]     r_rem;
    logic [nbst_pkg::LEN_W-1:0]     r_den;
    logic [nbst_pkg::FRAC_BITS-1:0] r_quot;
    logic [CNT_W-1:0]               r_cnt;
    logic                           r_busy;
    logic                           r_done;
    logic [nbst_pkg::LEN_W:0]       w_rem2;
    logic                           w_fit;

    // The remainder stays below the divisor, so the doubled value fits in
    // one extra bit and the difference fits back in the remainder width.
    assign w_rem2 = {r_rem, 1'b0};
    assign w_fit  = (w_rem2 >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(nbst_pkg::FRAC_BITS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= i_num;
            r_den  <= i_den;
            r_quot <= '0;
        end else if (r_busy) begin
            if (w_fit) begin
                r_rem <= nbst_pkg::LEN_W'(w_rem2 - {1'b0, r_den});
            end else begin
                r_rem <= w_rem2[nbst_pkg::LEN_W-1:0];
            end
            r_quot <= {r_quot[nbst_pkg::FRAC_BITS-2:0], w_fit};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

`default_nettype wire

/* rtl/nearest_bone_segment_tracker.sv */
// Top level of the nearest bone segment tracker: input decode, sequencer and
// the datapath registers around the shared multiplier and the divider.
// Depends on nbst_pkg, nbst_mac and nbst_div.
//
// Usage: each transfer on the slave stream carries one candidate segment for
// the current vertex. The block finds the point of the segment closest to the
// vertex, keeps the nearest candidate seen so far and, on a candidate whose
// last flag is set, sends one transfer on the master stream holding both joint
// ids and the position along the segment. A vertex should open with a forced
// candidate, since the kept best is not cleared between vertices.
// Timing: one candidate is in work at a time and s_axis_tready is low while
// it is. Three three-term sums run on the shared multiplier, then a decision
// state; a degenerate candidate then goes to its update, and one outside the
// segment first takes one more multiplier pass for the distance to the end.
// An inside projection runs the divider steps, takes the quotient and makes
// two more multiplier passes before its update. The block returns to idle
// before it takes the next transfer; the result appears on the master stream
// on the cycle after the update.
// A result waits in an output register; if the receiver stalls, new candidates
// are still taken, and only a following last candidate waits at its update.
// Reset clears the kept best to zero and the threshold register to one.
`default_nettype none

module nearest_bone_segment_tracker (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    // Configuration: degenerate squared-length threshold.
    input  wire logic                               i_cfg_wr_en,
    input  wire logic [nbst_pkg::THR_W-1:0]         i_cfg_wr_data,
    // Candidate stream.
    input  wire logic                               s_axis_tvalid,
    output logic                                    s_axis_tready,
    // From bit 0: point_x, point_y, point_z, start_x, start_y, start_z,
    // end_x, end_y, end_z (24 bits each), origin_joint, end_joint (8 each).
    input  wire logic [nbst_pkg::S_DATA_W-1:0]      s_axis_tdata,
    // run_position: bit 0 forces replacement, bit 1 marks the last candidate.
    input  wire logic [nbst_pkg::RUN_W-1:0]         s_axis_tuser,
    // Result stream.
    output logic                                    m_axis_tvalid,
    input  wire logic                               m_axis_tready,
    // From bit 0: best_origin (8), best_end (8), best_alpha (17), zero fill.
    output logic [nbst_pkg::M_DATA_W-1:0]           m_axis_tdata
);

    localparam int CW = nbst_pkg::COORD_W;
    localparam int JW = nbst_pkg::JOINT_W;

    nbst_pkg::t_state   r_state;
    nbst_pkg::t_state   n_state;
    logic [1:0]         r_cnt;
    logic [1:0]         w_sel;
    logic [1:0]         w_prev;
    logic               w_last_step;

    // Per-candidate operands: segment direction, vertex minus start and
    // vertex minus end, plus the projection residual.
    logic signed [nbst_pkg::DIFF_W-1:0] r_d [3];
    logic signed [nbst_pkg::DIFF_W-1:0] r_q [3];
    logic signed [nbst_pkg::DIFF_W-1:0] r_e [3];
    logic signed [nbst_pkg::OP_W-1:0]   r_r [3];
    logic signed [nbst_pkg::DIFF_W-1:0] w_d [3];
    logic signed [nbst_pkg::DIFF_W-1:0] w_q [3];
    logic signed [nbst_pkg::DIFF_W-1:0] w_e [3];

    logic [JW-1:0]                      r_cand_origin;
    logic [JW-1:0]                      r_cand_end;
    logic [nbst_pkg::RUN_W-1:0]         r_run;

    logic [nbst_pkg::THR_W-1:0]         r_thr;
    logic [nbst_pkg::LEN_W-1:0]         r_len;
    logic [nbst_pkg::DIST_W-1:0]        r_dpa;
    logic signed [nbst_pkg::ACC_W-1:0]  r_dot;
    logic [nbst_pkg::DIST_W-1:0]        r_dist;
    logic [nbst_pkg::ALPHA_W-1:0]       r_alpha;

    // Kept best.
    logic [nbst_pkg::DIST_W-1:0]        r_least;
    logic [JW-1:0]                      r_held_origin;
    logic [JW-1:0]                      r_held_end;
    logic [nbst_pkg::ALPHA_W-1:0]       r_held_alpha;

    logic                               r_m_valid;
    logic [nbst_pkg::M_DATA_W-1:0]      r_m_data;

    nbst_pkg::t_mac_ctl                 w_mac_ctl;
    logic signed [nbst_pkg::OP_W-1:0]   w_op_a;
    logic signed [nbst_pkg::OP_W-1:0]   w_op_b;
    logic signed [nbst_pkg::PROD_W-1:0] w_prod;
    logic signed [nbst_pkg::ACC_W-1:0]  w_sum;
    logic [nbst_pkg::DIST_W-1:0]        w_sum_u;
    logic signed [nbst_pkg::OP_W-1:0]   w_term;

    logic                               w_div_start;
    logic                               w_div_done;
    logic [nbst_pkg::FRAC_BITS-1:0]     w_quot;

    logic                               w_accept;
    logic                               w_degenerate;
    logic                               w_inside;
    logic                               w_is_last;
    logic                               w_stall;
    logic                               w_replace;
    logic                               w_emit;
    logic [JW-1:0]                      w_new_origin;
    logic [JW-1:0]                      w_new_end;
    logic [nbst_pkg::ALPHA_W-1:0]       w_new_alpha;

    // ------------------------------------------------------------------
    // Input decode and differences.
    // ------------------------------------------------------------------
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_d[i] = $signed({s_axis_tdata[CW*(6+i)+CW-1], s_axis_tdata[CW*(6+i) +: CW]})
                   - $signed({s_axis_tdata[CW*(3+i)+CW-1], s_axis_tdata[CW*(3+i) +: CW]});
            w_q[i] = $signed({s_axis_tdata[CW*i+CW-1], s_axis_tdata[CW*i +: CW]})
                   - $signed({s_axis_tdata[CW*(3+i)+CW-1], s_axis_tdata[CW*(3+i) +: CW]});
            w_e[i] = $signed({s_axis_tdata[CW*i+CW-1], s_axis_tdata[CW*i +: CW]})
                   - $signed({s_axis_tdata[CW*(6+i)+CW-1], s_axis_tdata[CW*(6+i) +: CW]});
        end
    end

    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (r_state == nbst_pkg::ST_IDLE);

    // The step counter picks the coordinate fed to the multiplier; the
    // product of each step lands in the product register in the cycle after.
    assign w_last_step = (r_cnt == 2'd3);
    assign w_sel       = w_last_step ? 2'd0 : r_cnt;
    assign w_prev      = r_cnt - 2'd1;

    assign w_sum_u  = w_sum[nbst_pkg::DIST_W-1:0];
    assign w_term   = w_prod[nbst_pkg::FRAC_BITS + nbst_pkg::OP_W - 1 : nbst_pkg::FRAC_BITS];

    // A segment whose squared length is at or below the threshold is a point.
    assign w_degenerate = (r_len <= {{(nbst_pkg::LEN_W - nbst_pkg::THR_W){1'b0}}, r_thr});
    // The projection lies inside when 0 <= dot < squared length.
    assign w_inside = !r_dot[nbst_pkg::ACC_W-1]
                   && (r_dot[nbst_pkg::ACC_W-2:0] < (nbst_pkg::ACC_W-1)'(r_len));

    assign w_is_last = r_run[nbst_pkg::RUN_LAST];
    assign w_stall   = w_is_last && r_m_valid && !m_axis_tready;
    assign w_replace = r_run[nbst_pkg::RUN_FORCE] || (r_dist < r_least);
    assign w_emit    = (r_state == nbst_pkg::ST_UPDATE) && !w_stall && w_is_last;

    assign w_new_origin = w_replace ? r_cand_origin : r_held_origin;
    assign w_new_end    = w_replace ? r_cand_end    : r_held_end;
    assign w_new_alpha  = w_replace ? r_alpha       : r_held_alpha;

    // ------------------------------------------------------------------
    // Sequencer: next state.
    // ------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        unique case (r_state) inside
            nbst_pkg::ST_IDLE: begin
                if (w_accept) begin
                    n_state = nbst_pkg::ST_LEN;
                end
            end
            nbst_pkg::ST_LEN: begin
                if (w_last_step) begin
                    n_state = nbst_pkg::ST_DPA;
                end
            end
            nbst_pkg::ST_DPA: begin
                if (w_last_step) begin
                    n_state = nbst_pkg::ST_DOT;
                end
            end
            nbst_pkg::ST_DOT: begin
                if (w_last_step) begin
                    n_state = nbst_pkg::ST_DECIDE;
                end
            end
            nbst_pkg::ST_DECIDE: begin
                if (w_degenerate) begin
                    n_state = nbst_pkg::ST_UPDATE;
                end else if (w_inside) begin
                    n_state = nbst_pkg::ST_DIV;
                end else begin
                    n_state = nbst_pkg::ST_DPB;
                end
            end
            nbst_pkg::ST_DIV: begin
                if (w_div_done) begin
                    n_state = nbst_pkg::ST_SCALE;
                end
            end
            nbst_pkg::ST_SCALE: begin
                if (w_last_step) begin
                    n_state = nbst_pkg::ST_RSQ;
                end
            end
            nbst_pkg::ST_RSQ, nbst_pkg::ST_DPB: begin
                if (w_last_step) begin
                    n_state = nbst_pkg::ST_UPDATE;
                end
            end
            nbst_pkg::ST_UPDATE: begin
                if (!w_stall) begin
                    n_state = nbst_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = nbst_pkg::ST_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Sequencer: outputs to the shared multiplier and the divider.
    // ------------------------------------------------------------------
    always_comb begin
        w_mac_ctl   = '0;
        w_op_a      = '0;
        w_op_b      = '0;
        w_div_start = 1'b0;
        unique case (r_state)
            nbst_pkg::ST_LEN: begin
                w_op_a = nbst_pkg::OP_W'(r_d[w_sel]);
                w_op_b = nbst_pkg::OP_W'(r_d[w_sel]);
            end
            nbst_pkg::ST_DPA: begin
                w_op_a = nbst_pkg::OP_W'(r_q[w_sel]);
                w_op_b = nbst_pkg::OP_W'(r_q[w_sel]);
            end
            nbst_pkg::ST_DOT: begin
                w_op_a = nbst_pkg::OP_W'(r_q[w_sel]);
                w_op_b = nbst_pkg::OP_W'(r_d[w_sel]);
            end
            nbst_pkg::ST_DPB: begin
                w_op_a = nbst_pkg::OP_W'(r_e[w_sel]);
                w_op_b = nbst_pkg::OP_W'(r_e[w_sel]);
            end
            nbst_pkg::ST_RSQ: begin
                w_op_a = r_r[w_sel];
                w_op_b = r_r[w_sel];
            end
            nbst_pkg::ST_SCALE: begin
                w_op_a = $signed(nbst_pkg::OP_W'(r_alpha));
                w_op_b = nbst_pkg::OP_W'(r_d[w_sel]);
            end
            nbst_pkg::ST_DECIDE: begin
                w_div_start = !w_degenerate && w_inside;
            end
            default: begin
            end
        endcase

        // Every multiplier pass is three multiplies and a closing step.
        unique case (r_state) inside
            nbst_pkg::ST_LEN, nbst_pkg::ST_DPA, nbst_pkg::ST_DOT,
            nbst_pkg::ST_DPB, nbst_pkg::ST_RSQ: begin
                w_mac_ctl.mul_en  = !w_last_step;
                w_mac_ctl.acc_clr = (r_cnt == 2'd0);
                w_mac_ctl.acc_en  = (r_cnt == 2'd1) || (r_cnt == 2'd2);
            end
            nbst_pkg::ST_SCALE: begin
                w_mac_ctl.mul_en  = !w_last_step;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= nbst_pkg::ST_IDLE;
            r_cnt   <= 2'd0;
        end else begin
            r_state <= n_state;
            r_cnt   <= (n_state != r_state) ? 2'd0 : r_cnt + 2'd1;
        end
    end

    // ------------------------------------------------------------------
    // Candidate datapath registers.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            for (int i = 0; i < 3; i++) begin
                r_d[i] <= w_d[i];
                r_q[i] <= w_q[i];
                r_e[i] <= w_e[i];
            end
            r_cand_origin <= s_axis_tdata[9*CW +: JW];
            r_cand_end    <= s_axis_tdata[9*CW+JW +: JW];
            r_run         <= s_axis_tuser;
        end

        if (w_last_step) begin
            unique case (r_state)
                nbst_pkg::ST_LEN: r_len <= w_sum[nbst_pkg::LEN_W-1:0];
                nbst_pkg::ST_DPA: r_dpa <= w_sum_u;
                nbst_pkg::ST_DOT: r_dot <= w_sum;
                nbst_pkg::ST_RSQ: r_dist <= w_sum_u;
                nbst_pkg::ST_DPB: begin
                    // Outside the segment: the start wins only when strictly nearer.
                    if (r_dpa < w_sum_u) begin
                        r_dist  <= r_dpa;
                        r_alpha <= '0;
                    end else begin
                        r_dist  <= w_sum_u;
                        r_alpha <= nbst_pkg::ALPHA_ONE;
                    end
                end
                default: begin
                end
            endcase
        end

        // Vertex minus projected point, with the scaled direction floored.
        if (r_state == nbst_pkg::ST_SCALE && r_cnt != 2'd0) begin
            r_r[w_prev] <= nbst_pkg::OP_W'(r_q[w_prev]) - w_term;
        end

        if (r_state == nbst_pkg::ST_DECIDE && w_degenerate) begin
            r_dist  <= r_dpa;
            r_alpha <= '0;
        end

        if (r_state == nbst_pkg::ST_DIV && w_div_done) begin
            r_alpha <= nbst_pkg::ALPHA_W'(w_quot);
        end
    end

    // ------------------------------------------------------------------
    // Threshold register, kept best and output register.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr         <= nbst_pkg::THR_RESET;
            r_least       <= '0;
            r_held_origin <= '0;
            r_held_end    <= '0;
            r_held_alpha  <= '0;
            r_m_valid     <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_thr <= i_cfg_wr_data;
            end

            // A new result replaces one that leaves in the same cycle.
            if (w_emit) begin
                r_m_valid <= 1'b1;
            end else if (r_m_valid && m_axis_tready) begin
                r_m_valid <= 1'b0;
            end

            if (r_state == nbst_pkg::ST_UPDATE && !w_stall && w_replace) begin
                r_least       <= r_dist;
                r_held_origin <= r_cand_origin;
                r_held_end    <= r_cand_end;
                r_held_alpha  <= r_alpha;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_m_data <= nbst_pkg::M_DATA_W'({w_new_alpha, w_new_end, w_new_origin});
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;

    // ------------------------------------------------------------------
    // Shared arithmetic units.
    // ------------------------------------------------------------------
    nbst_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_mac_ctl),
        .i_op_a  (w_op_a),
        .i_op_b  (w_op_b),
        .o_prod  (w_prod),
        .o_sum   (w_sum)
    );

    nbst_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (r_dot[nbst_pkg::LEN_W-1:0]),
        .i_den   (r_len),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

endmodule

`default_nettype wire
